FILE: design/chmc_pkg.sv
// Shared types, constants and table functions for the chassis mode and motion command block.
// No dependencies; every other file in this folder imports this package.
package chmc_pkg;

  // Fixed-point and table setup
  localparam int SINE_DEPTH    = 1024;
  localparam int FRACTION_BITS = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int FULL_TURN   = 23040;            // 360 degrees in 1/64 degree
  localparam int HALF_TURN   = FULL_TURN / 2;
  localparam int QUARTER     = SINE_DEPTH / 4;
  localparam int QTR_BITS    = $clog2(QUARTER);
  localparam int PHASE_BITS  = $clog2(SINE_DEPTH);
  localparam int K_W         = PHASE_BITS + 1;
  localparam int ANG_W       = $clog2(FULL_TURN);
  localparam int NUM_W       = $clog2(FULL_TURN * SINE_DEPTH);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Reciprocal of FULL_TURN, exact for every NUM_W-bit numerator
  localparam int RECIP_SH = 40;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + FULL_TURN - 1) / FULL_TURN;
  localparam int RECIP_W  = $clog2(RECIP + 1);

  // Field widths
  localparam int STICK_W = 11;
  localparam int TAB_W   = 15;                   // Q14 magnitude, up to 16384
  localparam int TRIG_W  = TAB_W + 1;
  localparam int PROD_W  = STICK_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int VEL_LIMIT = 660;

  // Rescaling between 1/64 units and 2^-FRACTION_BITS units
  localparam int ROT_SH  = 14 - FRACTION_BITS;
  localparam int ROT_RND = 1 << (ROT_SH - 1);
  localparam int UP_SH   = (FRACTION_BITS >= 6) ? FRACTION_BITS - 6 : 0;
  localparam int DN_SH   = (FRACTION_BITS < 6) ? 6 - FRACTION_BITS : 0;
  localparam int DN_RND  = (DN_SH > 0) ? (1 << (DN_SH - 1)) : 0;
  localparam int INT_W   = 19 + UP_SH;

  // Switch and key codes
  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_MID  = 2'd2;
  localparam logic [1:0] SW_DOWN = 2'd3;
  localparam logic [1:0] PSW_DOWN = 2'd3;

  localparam int KEY_W = 0;
  localparam int KEY_S = 1;
  localparam int KEY_A = 2;
  localparam int KEY_D = 3;
  localparam int KEY_Q = 4;
  localparam int KEY_E = 5;
  localparam int KEY_F = 6;
  localparam int KEY_G = 7;

  typedef enum logic [1:0] {
    MODE_FOLLOW   = 2'd0,
    MODE_NOFOLLOW = 2'd1,
    MODE_SPIN     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DRIVE_LOCK  = 2'd0,
    DRIVE_SPEED = 2'd1,
    DRIVE_ZERO  = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    CFG_SPIN_RATE      = 2'd0,
    CFG_LOCK_DEADBAND  = 2'd1,
    CFG_KEY_FULL_SCALE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [16:0] spin_rate;
    logic [11:0]        lock_deadband;
    logic [9:0]         key_full_scale;
  } cfg_t;

  // One classified item on its way from front to back
  typedef struct packed {
    mode_t                     mode;
    logic signed [STICK_W-1:0] vx;
    logic signed [STICK_W-1:0] vy;
    logic signed [STICK_W-1:0] syaw;
    logic signed [14:0]        ang;
    logic [1:0]                psw;
    logic [NUM_W-1:0]          num;
  } front_item_t;

  // 1/64 units to 2^-FRACTION_BITS units, rounding half up when narrowing
  function automatic logic signed [INT_W-1:0] to_frac(input logic signed [INT_W-1:0] v);
    if (UP_SH > 0) begin
      return v <<< UP_SH;
    end
    return (v + $signed(INT_W'(DN_RND))) >>> DN_SH;
  endfunction

  // Q14 sine or cosine of quarter-wave step r, from a Q30 Taylor series
  function automatic logic [TAB_W-1:0] quarter_wave(input int r, input bit want_cos);
    longint unsigned x, x2, ts, tc;
    longint ss, cs, v;
    x  = (64'(4 * r) * HALF_PI_Q30) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(64'd1 << 30);
    for (int i = 1; i <= 7; i++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
      if ((i & 1) != 0) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (cs < 0) cs = 0;
    v = want_cos ? cs : ss;
    return TAB_W'((v + (longint'(1) << 15)) >>> 16);
  endfunction

endpackage

FILE: design/chmc_front.sv
// Front end: input handshake, mode selection state and velocity/angle classification.
// Depends on chmc_pkg; writes one front_item_t per accepted beat into the queue.
module chmc_front
  import chmc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [STICK_W-1:0] in_stick_x,
  input  logic signed [STICK_W-1:0] in_stick_y,
  input  logic signed [STICK_W-1:0] in_stick_yaw,
  input  logic [1:0]                in_mode_switch,
  input  logic [1:0]                in_power_switch,
  input  logic [7:0]                in_keys,
  input  logic signed [14:0]        in_relative_angle,
  input  logic [9:0]                key_full_scale,
  input  logic                      q_full,
  output logic                      push,
  output front_item_t               item
);

  mode_t sw_choice_r, sw_choice_nxt;
  mode_t key_choice_r, key_choice_nxt;
  mode_t mode_r, mode_nxt;
  logic  acc;

  logic signed [STICK_W:0]   kfs, kdrv_x, kdrv_y;
  logic signed [STICK_W-1:0] vx, vy;
  logic [16:0]               ang_ofs;
  logic [ANG_W-1:0]          am;

  function automatic logic signed [STICK_W-1:0] clamp_vel(input logic signed [STICK_W:0] v);
    if (v > $signed((STICK_W+1)'(VEL_LIMIT))) begin
      return $signed(STICK_W'(VEL_LIMIT));
    end else if (v < -$signed((STICK_W+1)'(VEL_LIMIT))) begin
      return -$signed(STICK_W'(VEL_LIMIT));
    end
    return v[STICK_W-1:0];
  endfunction

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = acc;

  always_comb begin
    sw_choice_nxt = sw_choice_r;
    unique case (in_mode_switch)
      SW_UP:   sw_choice_nxt = MODE_SPIN;
      SW_MID:  sw_choice_nxt = MODE_FOLLOW;
      SW_DOWN: sw_choice_nxt = MODE_NOFOLLOW;
      default: sw_choice_nxt = sw_choice_r;
    endcase

    if (in_keys[KEY_G])      key_choice_nxt = MODE_NOFOLLOW;
    else if (in_keys[KEY_F]) key_choice_nxt = MODE_FOLLOW;
    else if (in_keys[KEY_E]) key_choice_nxt = MODE_SPIN;
    else if (in_keys[KEY_Q]) key_choice_nxt = MODE_FOLLOW;
    else                     key_choice_nxt = key_choice_r;

    // a key change overrides a switch change on the same tick
    mode_nxt = mode_r;
    if (sw_choice_nxt != sw_choice_r) mode_nxt = sw_choice_nxt;
    if (key_choice_nxt != key_choice_r) mode_nxt = key_choice_nxt;
  end

  always_comb begin
    kfs = $signed((STICK_W+1)'(key_full_scale));
    if (in_keys[KEY_D] && !in_keys[KEY_A])      kdrv_x = kfs;
    else if (in_keys[KEY_A] && !in_keys[KEY_D]) kdrv_x = -kfs;
    else                                        kdrv_x = '0;
    if (in_keys[KEY_W] && !in_keys[KEY_S])      kdrv_y = kfs;
    else if (in_keys[KEY_S] && !in_keys[KEY_W]) kdrv_y = -kfs;
    else                                        kdrv_y = '0;
    vx = clamp_vel((STICK_W+1)'(in_stick_x) + kdrv_x);
    vy = clamp_vel((STICK_W+1)'(in_stick_y) + kdrv_y);

    // angle folded into [0, FULL_TURN): one compare and subtract
    ang_ofs = $unsigned(17'(in_relative_angle)) + 17'(FULL_TURN);
    if (ang_ofs >= 17'(FULL_TURN)) am = ANG_W'(ang_ofs - 17'(FULL_TURN));
    else                           am = ANG_W'(ang_ofs);

    item.mode = mode_nxt;
    item.vx   = vx;
    item.vy   = vy;
    item.syaw = in_stick_yaw;
    item.ang  = in_relative_angle;
    item.psw  = in_power_switch;
    item.num  = (NUM_W'(am) << PHASE_BITS) + NUM_W'(HALF_TURN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_choice_r  <= MODE_FOLLOW;
      key_choice_r <= MODE_FOLLOW;
      mode_r       <= MODE_FOLLOW;
    end else if (acc) begin
      sw_choice_r  <= sw_choice_nxt;
      key_choice_r <= key_choice_nxt;
      mode_r       <= mode_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_key_g_wins: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_keys[KEY_G]) |=> (key_choice_r == MODE_NOFOLLOW))
    else $error("G key did not select no-follow");

  a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(mode_r))
    else $error("mode changed without an accepted beat");
`endif

endmodule

FILE: design/chmc_queue.sv
// Short register FIFO of classified items between front and back.
// Depends on chmc_pkg for front_item_t.
module chmc_queue
  import chmc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t wr_item,
  input  logic        pop,
  output front_item_t rd_item,
  output logic        rd_valid,
  output logic        full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign rd_valid = (count_r != '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

`ifndef NO_ASSERTIONS
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count lost a push");
`endif

endmodule

FILE: design/chmc_back.sv
// Back end: phase lookup, rotation, yaw and drive-state decision, output register.
// Depends on chmc_pkg; four stages that advance together on a single enable.
module chmc_back
  import chmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  front_item_t        head,
  output logic               pop,
  input  cfg_t               cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_command_x,
  output logic signed [16:0] out_command_y,
  output logic signed [17:0] out_command_yaw,
  output logic [1:0]         out_mode_now,
  output logic [1:0]         out_drive_now,
  output logic               out_encoder_reset
);

  logic adv;

  // quarter-wave tables, constant
  logic [TAB_W-1:0] sin_tab [QUARTER];
  logic [TAB_W-1:0] cos_tab [QUARTER];

  for (genvar g = 0; g < QUARTER; g++) begin : g_tab
    assign sin_tab[g] = quarter_wave(g, 1'b0);
    assign cos_tab[g] = quarter_wave(g, 1'b1);
  end

  // stage 1: phase index
  logic                        s1_v_r;
  front_item_t                 s1_item_r;
  logic [PHASE_BITS-1:0]       s1_k_r;
  logic [NUM_W+RECIP_W-1:0]    k_prod;
  logic [K_W-1:0]              k_raw;
  logic [PHASE_BITS-1:0]       k_wrap;

  // stage 2: sine and cosine
  logic                        s2_v_r;
  front_item_t                 s2_item_r;
  logic signed [TRIG_W-1:0]    s2_sn_r, s2_cs_r;
  logic [1:0]                  quad;
  logic [QTR_BITS-1:0]         qidx;
  logic [TAB_W-1:0]            s_mag, c_mag, sn_mag, cs_mag;

  // stage 3: products
  logic                        s3_v_r;
  front_item_t                 s3_item_r;
  logic signed [PROD_W-1:0]    p_xc_r, p_ys_r, p_yc_r, p_xs_r;

  // stage 4: commands and drive decision
  logic signed [SUM_W-1:0]     rx_sum, ry_sum;
  logic signed [INT_W-1:0]     cx, cy, cyaw, yaw_base, db;
  drive_t                      dec, drive_nxt, drive_r;
  logic                        enc;

  logic                        out_valid_r;
  logic signed [16:0]          out_cx_r, out_cy_r;
  logic signed [17:0]          out_cyaw_r;
  mode_t                       out_mode_r;
  logic                        out_enc_r;

  function automatic logic in_band(input logic signed [INT_W-1:0] v,
                                   input logic signed [INT_W-1:0] lim);
    return (v < lim) && (v > -lim);
  endfunction

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && head_valid;

  always_comb begin
    k_prod = NUM_W'(head.num) * RECIP_W'(RECIP);
    k_raw  = k_prod[RECIP_SH +: K_W];
    if (k_raw >= K_W'(SINE_DEPTH)) k_wrap = PHASE_BITS'(k_raw - K_W'(SINE_DEPTH));
    else                           k_wrap = PHASE_BITS'(k_raw);
  end

  always_comb begin
    quad   = s1_k_r[PHASE_BITS-1 -: 2];
    qidx   = s1_k_r[QTR_BITS-1:0];
    s_mag  = sin_tab[qidx];
    c_mag  = cos_tab[qidx];
    sn_mag = quad[0] ? c_mag : s_mag;
    cs_mag = quad[0] ? s_mag : c_mag;
  end

  always_comb begin
    rx_sum = SUM_W'(p_xc_r) - SUM_W'(p_ys_r);
    ry_sum = SUM_W'(p_yc_r) + SUM_W'(p_xs_r);

    if (s3_item_r.mode == MODE_FOLLOW) begin
      cx = INT_W'(s3_item_r.vx) <<< FRACTION_BITS;
      cy = INT_W'(s3_item_r.vy) <<< FRACTION_BITS;
    end else begin
      cx = INT_W'((rx_sum + $signed(SUM_W'(ROT_RND))) >>> ROT_SH);
      cy = INT_W'((ry_sum + $signed(SUM_W'(ROT_RND))) >>> ROT_SH);
    end

    unique case (s3_item_r.mode)
      MODE_FOLLOW:   yaw_base = to_frac(INT_W'(s3_item_r.ang));
      MODE_NOFOLLOW: yaw_base = '0;
      MODE_SPIN:     yaw_base = to_frac(INT_W'(cfg.spin_rate));
      default:       yaw_base = '0;
    endcase
    cyaw = yaw_base + (INT_W'(s3_item_r.syaw) <<< FRACTION_BITS);

    db  = to_frac($signed(INT_W'(cfg.lock_deadband)));
    dec = (in_band(cx, db) && in_band(cy, db) && in_band(cyaw, db)) ? DRIVE_LOCK
                                                                    : DRIVE_SPEED;
    enc = (dec != drive_r);
    drive_nxt = (s3_item_r.psw == PSW_DOWN) ? DRIVE_ZERO : dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      drive_r     <= DRIVE_LOCK;
    end else if (adv) begin
      s1_v_r      <= head_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
      if (s3_v_r) drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= head;
      s1_k_r    <= k_wrap;

      s2_item_r <= s1_item_r;
      s2_sn_r   <= quad[1] ? -$signed({1'b0, sn_mag}) : $signed({1'b0, sn_mag});
      s2_cs_r   <= (quad[1] ^ quad[0]) ? -$signed({1'b0, cs_mag}) : $signed({1'b0, cs_mag});

      s3_item_r <= s2_item_r;
      p_xc_r    <= s2_item_r.vx * s2_cs_r;
      p_ys_r    <= s2_item_r.vy * s2_sn_r;
      p_yc_r    <= s2_item_r.vy * s2_cs_r;
      p_xs_r    <= s2_item_r.vx * s2_sn_r;

      if (s3_v_r) begin
        out_cx_r   <= cx[16:0];
        out_cy_r   <= cy[16:0];
        out_cyaw_r <= cyaw[17:0];
        out_mode_r <= s3_item_r.mode;
        out_enc_r  <= enc;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_x     = out_cx_r;
  assign out_command_y     = out_cy_r;
  assign out_command_yaw   = out_cyaw_r;
  assign out_mode_now      = out_mode_r;
  assign out_drive_now     = drive_r;
  assign out_encoder_reset = out_enc_r;

`ifndef NO_ASSERTIONS
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_v_r, s2_v_r, s3_v_r}))
    else $error("pipeline moved while output stalled");

  a_power_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_v_r && (s3_item_r.psw == PSW_DOWN)) |=>
      (out_valid_r && (drive_r == DRIVE_ZERO)))
    else $error("power switch down did not force zero force");
`endif

endmodule

FILE: design/chassis_mode_and_motion_command.sv
// Top level of the chassis mode and motion command block: config registers and wiring.
// Depends on chmc_pkg, chmc_front, chmc_queue and chmc_back.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat per control tick carrying the three
//    stick channels, both switches, the key bits and the gimbal-to-chassis angle.
//  - Result channel (out_valid/out_ready): one beat per input beat, in order, with the
//    x/y/yaw commands, the mode in force, the drive state and the encoder-reset pulse.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 spin_rate, 1 lock_deadband,
//    2 key_full_scale; index 3 is ignored. Write only while the block is idle.
//  - Throughput: one beat per cycle, sustained, when out_ready stays high. From input
//    acceptance to out_valid the queue entry feeds a phase reciprocal stage, a
//    quarter-wave table stage, a four-multiplier stage and the command/decision stage
//    that loads the output register.
//  - Stall: a low out_ready with out_valid high freezes the back pipeline; the front
//    keeps taking beats until the QUEUE_DEPTH-entry queue fills, then in_ready drops.
//  - Reset (rst_n low, synchronous): mode follow, drive lock, pipeline and queue empty,
//    config back to spin_rate 0, lock_deadband 320, key_full_scale 660.
module chassis_mode_and_motion_command
  import chmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [10:0] in_stick_x,
  input  logic signed [10:0] in_stick_y,
  input  logic signed [10:0] in_stick_yaw,
  input  logic [1:0]         in_mode_switch,
  input  logic [1:0]         in_power_switch,
  input  logic [7:0]         in_keys,
  input  logic signed [14:0] in_relative_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_command_x,
  output logic signed [16:0] out_command_y,
  output logic signed [17:0] out_command_yaw,
  output logic [1:0]         out_mode_now,
  output logic [1:0]         out_drive_now,
  output logic               out_encoder_reset,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  cfg_t        cfg_r;
  logic        push, pop, q_full, head_valid;
  front_item_t wr_item, head;

  // config registers: plain writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spin_rate      <= '0;
      cfg_r.lock_deadband  <= 12'd320;
      cfg_r.key_full_scale <= 10'd660;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPIN_RATE:      cfg_r.spin_rate      <= $signed(cfg_data);
        CFG_LOCK_DEADBAND:  cfg_r.lock_deadband  <= cfg_data[11:0];
        CFG_KEY_FULL_SCALE: cfg_r.key_full_scale <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // front: handshake, mode choice, key drive and clamp, angle fold
  chmc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stick_x        (in_stick_x),
    .in_stick_y        (in_stick_y),
    .in_stick_yaw      (in_stick_yaw),
    .in_mode_switch    (in_mode_switch),
    .in_power_switch   (in_power_switch),
    .in_keys           (in_keys),
    .in_relative_angle (in_relative_angle),
    .key_full_scale    (cfg_r.key_full_scale),
    .q_full            (q_full),
    .push              (push),
    .item              (wr_item)
  );

  // decouples the front from back-pressure on the result channel
  chmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (wr_item),
    .pop      (pop),
    .rd_item  (head),
    .rd_valid (head_valid),
    .full     (q_full)
  );

  // back: rotation, yaw, drive state and output register
  chmc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command_x     (out_command_x),
    .out_command_y     (out_command_y),
    .out_command_yaw   (out_command_yaw),
    .out_mode_now      (out_mode_now),
    .out_drive_now     (out_drive_now),
    .out_encoder_reset (out_encoder_reset)
  );

endmodule
